/* design/tpac_pkg.sv */
// ----------------------------------------------------------------------------
// tpac_pkg
// Shared constants, payload types and a helper for the triangle measure block.
// ----------------------------------------------------------------------------
package tpac_pkg;

   localparam int CW          = 16;
   localparam int FW          = 8;
   localparam int SIDE_W      = 25;
   localparam int PERIM_W     = 27;
   localparam int AREA_W      = 39;
   localparam int SUM_W       = CW + 2;
   localparam int SQ_W        = 2 * CW;
   localparam int D2_W        = SQ_W + 1;
   localparam int SIDE_N      = SIDE_W;
   localparam int AREA_N      = 44;
   localparam int HERON_SHIFT = 2 * FW + 4;
   localparam int HALF_W      = PERIM_W;
   localparam int X_W         = 2 * PERIM_W;
   localparam int PROD_W      = 2 * X_W;
   localparam int DIV3_MUL    = 43691;
   localparam int DIV3_SHIFT  = 17;

   typedef struct packed {
      logic [CW-1:0] gq_x;
      logic [CW-1:0] gq_y;
      logic          neg_x;
      logic          neg_y;
   } cent_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  a;
      logic [SIDE_W-1:0]  b;
      logic [SIDE_W-1:0]  c;
      logic [PERIM_W-1:0] p;
      logic               deg;
      cent_type           cent;
   } band_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  side_ab;
      logic [SIDE_W-1:0]  side_bc;
      logic [SIDE_W-1:0]  side_ca;
      logic [PERIM_W-1:0] perimeter;
      logic [AREA_W-1:0]  area;
      logic [CW-1:0]      centroid_x;
      logic [CW-1:0]      centroid_y;
   } rsp_data_type;

   function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] d;
      logic [CW:0] n;
      d = {b[CW-1], b} - {a[CW-1], a};
      n = ~d + 1'b1;
      return d[CW] ? n[CW-1:0] : d[CW-1:0];
   endfunction

endpackage

/* design/tpac_req_if.sv */
// ----------------------------------------------------------------------------
// tpac_req_if
// Triangle input channel: three vertices with valid and ready.
// ----------------------------------------------------------------------------
interface tpac_req_if;
   logic                          valid;
   logic                          ready;
   logic signed [tpac_pkg::CW-1:0] ax;
   logic signed [tpac_pkg::CW-1:0] ay;
   logic signed [tpac_pkg::CW-1:0] bx;
   logic signed [tpac_pkg::CW-1:0] by;
   logic signed [tpac_pkg::CW-1:0] cx;
   logic signed [tpac_pkg::CW-1:0] cy;

   modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
   modport sink (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

/* design/tpac_rsp_if.sv */
// ----------------------------------------------------------------------------
// tpac_rsp_if
// Result channel: sides, perimeter, area and centroid with valid and ready.
// ----------------------------------------------------------------------------
interface tpac_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [tpac_pkg::SIDE_W-1:0]         side_ab;
   logic [tpac_pkg::SIDE_W-1:0]         side_bc;
   logic [tpac_pkg::SIDE_W-1:0]         side_ca;
   logic [tpac_pkg::PERIM_W-1:0]        perimeter;
   logic [tpac_pkg::AREA_W-1:0]         area;
   logic signed [tpac_pkg::CW-1:0]      centroid_x;
   logic signed [tpac_pkg::CW-1:0]      centroid_y;

   modport source (output valid, side_ab, side_bc, side_ca, perimeter, area,
                   centroid_x, centroid_y, input ready);
   modport sink (input valid, side_ab, side_bc, side_ca, perimeter, area,
                 centroid_x, centroid_y, output ready);
endinterface

/* design/tpac_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// tpac_sqrt_cell
// One root bit of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module tpac_sqrt_cell #(
   parameter int N = 25,
   parameter int W = 1
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*N-1:0] rad_i,
   input  logic [N+1:0]   rem_i,
   input  logic [N-1:0]   root_i,
   input  logic [W-1:0]   band_i,
   output logic [2*N-1:0] rad_o,
   output logic [N+1:0]   rem_o,
   output logic [N-1:0]   root_o,
   output logic [W-1:0]   band_o
);

   logic [N+1:0]   shifted;
   logic [N+1:0]   trial;
   logic           fits;
   logic [2*N-1:0] rad_in, rad_ff;
   logic [N+1:0]   rem_in, rem_ff;
   logic [N-1:0]   root_in, root_ff;
   logic [W-1:0]   band_ff;

   always_comb begin
      shifted = {rem_i[N-1:0], rad_i[2*N-1 -: 2]};
      trial   = {root_i, 2'b01};
      fits    = shifted >= trial;
      rem_in  = fits ? shifted - trial : shifted;
      root_in = {root_i[N-2:0], fits};
      rad_in  = {rad_i[2*N-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         band_ff <= band_i;
      end
   end

   assign rad_o  = rad_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign band_o = band_ff;

endmodule

/* design/tpac_isqrt.sv */
// ----------------------------------------------------------------------------
// tpac_isqrt
// Row of N registered square root cells; the truncated root leaves the last cell.
// ----------------------------------------------------------------------------
module tpac_isqrt #(
   parameter int N = 25,
   parameter int W = 1
) (
   input  logic           clock,
   input  logic           en,
   input  logic [2*N-1:0] rad,
   input  logic [W-1:0]   band_i,
   output logic [N-1:0]   root,
   output logic [W-1:0]   band_o
);

   logic [2*N-1:0] rad_w  [0:N];
   logic [N+1:0]   rem_w  [0:N];
   logic [N-1:0]   root_w [0:N];
   logic [W-1:0]   band_w [0:N];

   assign rad_w[0]  = rad;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign band_w[0] = band_i;

   for (genvar i = 0; i < N; i++) begin : g_cell
      tpac_sqrt_cell #(.N(N), .W(W)) u_cell (
         .clock  (clock),
         .en     (en),
         .rad_i  (rad_w[i]),
         .rem_i  (rem_w[i]),
         .root_i (root_w[i]),
         .band_i (band_w[i]),
         .rad_o  (rad_w[i+1]),
         .rem_o  (rem_w[i+1]),
         .root_o (root_w[i+1]),
         .band_o (band_w[i+1])
      );
   end

   assign root   = root_w[N];
   assign band_o = band_w[N];

endmodule

/* design/triangle_perimeter_area_centroid.sv */
// Throughput: one triangle per cycle while the output stage has room; the rate is
// set by the cell rows of the four square roots, which advance one root bit per cell per cycle.
// A two-entry output stage keeps input open while one result waits.
// Reset clears the valid pipeline and the output stage; no result is pending.
// ----------------------------------------------------------------------------
// triangle_perimeter_area_centroid
// Sides, perimeter, Heron area and centroid of an integer triangle.
// ----------------------------------------------------------------------------
module triangle_perimeter_area_centroid (
   input  logic      clock,
   input  logic      reset,
   tpac_req_if.sink   req_chan,
   tpac_rsp_if.source rsp_chan
);

   localparam int CW    = tpac_pkg::CW;
   localparam int SN    = tpac_pkg::SIDE_N;
   localparam int AN    = tpac_pkg::AREA_N;
   localparam int PW    = tpac_pkg::PERIM_W;
   localparam int HW    = tpac_pkg::HALF_W;
   localparam int DEPTH = 3 + SN + 5 + AN;
   localparam int BW    = $bits(tpac_pkg::band_type);

   logic en;
   logic accept;
   logic [DEPTH-1:0] vld_in, vld_ff;
   logic [1:0] cnt_in, cnt_ff;

   // Stage 1
   logic [CW-1:0] ux_ab_ff, uy_ab_ff, ux_bc_ff, uy_bc_ff, ux_ca_ff, uy_ca_ff;
   logic [tpac_pkg::SUM_W-1:0] gs_x_ff, gs_y_ff;
   // Stage 2
   logic [tpac_pkg::SQ_W-1:0] sx_ab_ff, sy_ab_ff, sx_bc_ff, sy_bc_ff, sx_ca_ff, sy_ca_ff;
   logic [tpac_pkg::SUM_W-2:0] ga_x_ff, ga_y_ff;
   logic gn_x_ff, gn_y_ff;
   logic [tpac_pkg::SUM_W-2:0] ga_x_in, ga_y_in;
   logic [tpac_pkg::SUM_W-1:0] gsn_x, gsn_y;
   // Stage 3
   logic [tpac_pkg::D2_W-1:0] d2_ab_ff, d2_bc_ff, d2_ca_ff;
   logic [CW-1:0] gq_x_ff, gq_y_ff;
   logic gn3_x_ff, gn3_y_ff;
   logic [tpac_pkg::SUM_W-2+CW:0] gm_x, gm_y;

   // Side roots
   logic [SN-1:0] r_ab, r_bc, r_ca;
   logic [CW-1:0] sb_x, sb_y;
   logic [1:0] sb_n;

   // Heron stages
   tpac_pkg::band_type h1_ff, h2_ff, h3_ff, h4_ff, h5_ff, band_out;
   logic [PW-1:0] q1_ff, q2_ff, q3_ff;
   logic [tpac_pkg::X_W-1:0] x1_ff, x2_ff;
   logic [tpac_pkg::X_W-1:0] pp_hh_ff, pp_hl_ff, pp_lh_ff, pp_ll_ff;
   logic [tpac_pkg::PROD_W-1:0] prod;
   logic [2*AN-1:0] arad_ff;
   logic [AN-1:0] a_root;
   logic [PW-1:0] p_in;
   logic deg_in;

   tpac_pkg::rsp_data_type res, out_ff, spare_ff;
   logic [CW-1:0] cq_x, cq_y;

   assign en       = cnt_ff != 2'd2;
   assign accept   = req_chan.valid && en;
   assign req_chan.ready = en;

   always_comb begin
      gsn_x   = ~gs_x_ff + 1'b1;
      gsn_y   = ~gs_y_ff + 1'b1;
      ga_x_in = gs_x_ff[tpac_pkg::SUM_W-1] ? gsn_x[tpac_pkg::SUM_W-2:0]
                                           : gs_x_ff[tpac_pkg::SUM_W-2:0];
      ga_y_in = gs_y_ff[tpac_pkg::SUM_W-1] ? gsn_y[tpac_pkg::SUM_W-2:0]
                                           : gs_y_ff[tpac_pkg::SUM_W-2:0];
      gm_x    = ga_x_ff * (CW)'(tpac_pkg::DIV3_MUL);
      gm_y    = ga_y_ff * (CW)'(tpac_pkg::DIV3_MUL);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_ab_ff <= tpac_pkg::abs_diff(req_chan.ax, req_chan.bx);
         uy_ab_ff <= tpac_pkg::abs_diff(req_chan.ay, req_chan.by);
         ux_bc_ff <= tpac_pkg::abs_diff(req_chan.bx, req_chan.cx);
         uy_bc_ff <= tpac_pkg::abs_diff(req_chan.by, req_chan.cy);
         ux_ca_ff <= tpac_pkg::abs_diff(req_chan.cx, req_chan.ax);
         uy_ca_ff <= tpac_pkg::abs_diff(req_chan.cy, req_chan.ay);
         gs_x_ff  <= (tpac_pkg::SUM_W)'(req_chan.ax) + (tpac_pkg::SUM_W)'(req_chan.bx)
                   + (tpac_pkg::SUM_W)'(req_chan.cx);
         gs_y_ff  <= (tpac_pkg::SUM_W)'(req_chan.ay) + (tpac_pkg::SUM_W)'(req_chan.by)
                   + (tpac_pkg::SUM_W)'(req_chan.cy);

         sx_ab_ff <= ux_ab_ff * ux_ab_ff;
         sy_ab_ff <= uy_ab_ff * uy_ab_ff;
         sx_bc_ff <= ux_bc_ff * ux_bc_ff;
         sy_bc_ff <= uy_bc_ff * uy_bc_ff;
         sx_ca_ff <= ux_ca_ff * ux_ca_ff;
         sy_ca_ff <= uy_ca_ff * uy_ca_ff;
         ga_x_ff  <= ga_x_in;
         ga_y_ff  <= ga_y_in;
         gn_x_ff  <= gs_x_ff[tpac_pkg::SUM_W-1];
         gn_y_ff  <= gs_y_ff[tpac_pkg::SUM_W-1];

         d2_ab_ff <= (tpac_pkg::D2_W)'(sx_ab_ff) + (tpac_pkg::D2_W)'(sy_ab_ff);
         d2_bc_ff <= (tpac_pkg::D2_W)'(sx_bc_ff) + (tpac_pkg::D2_W)'(sy_bc_ff);
         d2_ca_ff <= (tpac_pkg::D2_W)'(sx_ca_ff) + (tpac_pkg::D2_W)'(sy_ca_ff);
         gq_x_ff  <= gm_x[tpac_pkg::DIV3_SHIFT +: CW];
         gq_y_ff  <= gm_y[tpac_pkg::DIV3_SHIFT +: CW];
         gn3_x_ff <= gn_x_ff;
         gn3_y_ff <= gn_y_ff;
      end
   end

   tpac_isqrt #(.N(SN), .W(CW)) u_sqrt_ab (
      .clock (clock), .en (en),
      .rad   ({{(2*SN-tpac_pkg::D2_W-2*tpac_pkg::FW){1'b0}}, d2_ab_ff,
               {(2*tpac_pkg::FW){1'b0}}}),
      .band_i (gq_x_ff), .root (r_ab), .band_o (sb_x)
   );

   tpac_isqrt #(.N(SN), .W(CW)) u_sqrt_bc (
      .clock (clock), .en (en),
      .rad   ({{(2*SN-tpac_pkg::D2_W-2*tpac_pkg::FW){1'b0}}, d2_bc_ff,
               {(2*tpac_pkg::FW){1'b0}}}),
      .band_i (gq_y_ff), .root (r_bc), .band_o (sb_y)
   );

   tpac_isqrt #(.N(SN), .W(2)) u_sqrt_ca (
      .clock (clock), .en (en),
      .rad   ({{(2*SN-tpac_pkg::D2_W-2*tpac_pkg::FW){1'b0}}, d2_ca_ff,
               {(2*tpac_pkg::FW){1'b0}}}),
      .band_i ({gn3_x_ff, gn3_y_ff}), .root (r_ca), .band_o (sb_n)
   );

   assign p_in = PW'(r_ab) + PW'(r_bc) + PW'(r_ca);

   assign deg_in = ({h1_ff.a, 1'b0} > (PW+1)'(h1_ff.p))
                || ({h1_ff.b, 1'b0} > (PW+1)'(h1_ff.p))
                || ({h1_ff.c, 1'b0} > (PW+1)'(h1_ff.p));

   always_comb begin
      prod = (tpac_pkg::PROD_W)'(pp_ll_ff)
           + ((tpac_pkg::PROD_W)'(pp_hl_ff) << HW)
           + ((tpac_pkg::PROD_W)'(pp_lh_ff) << HW)
           + ((tpac_pkg::PROD_W)'(pp_hh_ff) << (2 * HW));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h1_ff.a          <= r_ab;
         h1_ff.b          <= r_bc;
         h1_ff.c          <= r_ca;
         h1_ff.p          <= p_in;
         h1_ff.deg        <= 1'b0;
         h1_ff.cent.gq_x  <= sb_x;
         h1_ff.cent.gq_y  <= sb_y;
         h1_ff.cent.neg_x <= sb_n[1];
         h1_ff.cent.neg_y <= sb_n[0];

         h2_ff     <= {h1_ff.a, h1_ff.b, h1_ff.c, h1_ff.p, deg_in, h1_ff.cent};
         q1_ff     <= h1_ff.p - PW'({h1_ff.a, 1'b0});
         q2_ff     <= h1_ff.p - PW'({h1_ff.b, 1'b0});
         q3_ff     <= h1_ff.p - PW'({h1_ff.c, 1'b0});

         h3_ff <= h2_ff;
         x1_ff <= h2_ff.p * q1_ff;
         x2_ff <= q2_ff * q3_ff;

         h4_ff    <= h3_ff;
         pp_hh_ff <= x1_ff[HW +: HW] * x2_ff[HW +: HW];
         pp_hl_ff <= x1_ff[HW +: HW] * x2_ff[HW-1:0];
         pp_lh_ff <= x1_ff[HW-1:0] * x2_ff[HW +: HW];
         pp_ll_ff <= x1_ff[HW-1:0] * x2_ff[HW-1:0];

         h5_ff   <= h4_ff;
         arad_ff <= prod[tpac_pkg::HERON_SHIFT +: 2*AN];
      end
   end

   tpac_isqrt #(.N(AN), .W(BW)) u_sqrt_area (
      .clock (clock), .en (en), .rad (arad_ff),
      .band_i (h5_ff), .root (a_root), .band_o (band_out)
   );

   always_comb begin
      cq_x = ~band_out.cent.gq_x + 1'b1;
      cq_y = ~band_out.cent.gq_y + 1'b1;
      res.side_ab    = band_out.a;
      res.side_bc    = band_out.b;
      res.side_ca    = band_out.c;
      res.perimeter  = band_out.p;
      if (band_out.deg) begin
         res.area = '0;
      end else if (|a_root[AN-1:tpac_pkg::AREA_W]) begin
         res.area = '1;
      end else begin
         res.area = a_root[tpac_pkg::AREA_W-1:0];
      end
      res.centroid_x = band_out.cent.neg_x ? cq_x : band_out.cent.gq_x;
      res.centroid_y = band_out.cent.neg_y ? cq_y : band_out.cent.gq_y;
   end

   logic push, pop;
   assign push = en && vld_ff[DEPTH-1];
   assign pop  = (cnt_ff != 2'd0) && rsp_chan.ready;

   always_comb begin
      vld_in = en ? {vld_ff[DEPTH-2:0], accept} : vld_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= 2'd0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && pop) begin
         if (cnt_ff == 2'd2) begin
            out_ff   <= spare_ff;
            spare_ff <= res;
         end else begin
            out_ff <= res;
         end
      end else if (push) begin
         if (cnt_ff == 2'd0) begin
            out_ff <= res;
         end else begin
            spare_ff <= res;
         end
      end else if (pop) begin
         out_ff <= spare_ff;
      end
   end

   assign rsp_chan.valid      = cnt_ff != 2'd0;
   assign rsp_chan.side_ab    = out_ff.side_ab;
   assign rsp_chan.side_bc    = out_ff.side_bc;
   assign rsp_chan.side_ca    = out_ff.side_ca;
   assign rsp_chan.perimeter  = out_ff.perimeter;
   assign rsp_chan.area       = out_ff.area;
   assign rsp_chan.centroid_x = out_ff.centroid_x;
   assign rsp_chan.centroid_y = out_ff.centroid_y;

endmodule

/* design/tpac_checker.sv */
// ----------------------------------------------------------------------------
// tpac_checker
// Port-level checks on the triangle measure block, attached by bind.
// ----------------------------------------------------------------------------
module tpac_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tpac_pkg::SIDE_W-1:0]   side_ab,
   input logic [tpac_pkg::SIDE_W-1:0]   side_bc,
   input logic [tpac_pkg::SIDE_W-1:0]   side_ca,
   input logic [tpac_pkg::PERIM_W-1:0]  perimeter,
   input logic [tpac_pkg::AREA_W-1:0]   area
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(area))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   a_ready_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input closed with no result waiting");

   a_perimeter: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> perimeter == tpac_pkg::PERIM_W'(side_ab) + tpac_pkg::PERIM_W'(side_bc)
                                 + tpac_pkg::PERIM_W'(side_ca))
      else $error("perimeter is not the sum of the sides");

   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ({side_ab, 1'b0} > (tpac_pkg::PERIM_W+1)'(perimeter)) |-> area == '0)
      else $error("degenerate triangle with nonzero area");

endmodule

bind triangle_perimeter_area_centroid tpac_checker u_tpac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .side_ab   (rsp_chan.side_ab),
   .side_bc   (rsp_chan.side_bc),
   .side_ca   (rsp_chan.side_ca),
   .perimeter (rsp_chan.perimeter),
   .area      (rsp_chan.area)
);

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the triangle measure block: random and corner triangles are sent
// through the input channel and each result is compared with a predictor.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct {
      logic signed [tpac_pkg::CW-1:0] ax, ay, bx, by, cx, cy;
   } tri_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tpac_req_if req_chan ();
   tpac_rsp_if rsp_chan ();

   triangle_perimeter_area_centroid u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #6 clock = ~clock;

   tpac_pkg::rsp_data_type measures_due[$];
   int           n_mismatch = 0;
   int           idle_cycles = 0;
   int           hold_cycles = 0;
   bit           stall_phase = 1'b0;

   function automatic logic [63:0] root128(logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         c = r | (64'd1 << i);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic [63:0] side_len(logic signed [tpac_pkg::CW-1:0] x0,
                                            logic signed [tpac_pkg::CW-1:0] y0,
                                            logic signed [tpac_pkg::CW-1:0] x1,
                                            logic signed [tpac_pkg::CW-1:0] y1);
      longint dx;
      longint dy;
      logic [127:0] d2;
      dx = longint'(x1) - longint'(x0);
      dy = longint'(y1) - longint'(y0);
      d2 = 128'(dx * dx + dy * dy);
      return root128(d2 << (2 * tpac_pkg::FW));
   endfunction

   function automatic tpac_pkg::rsp_data_type predict_measures(tri_type t);
      tpac_pkg::rsp_data_type r;
      logic [63:0]  a, b, c, p, ar;
      logic [127:0] prod;
      longint       gx, gy;
      a = side_len(t.ax, t.ay, t.bx, t.by);
      b = side_len(t.bx, t.by, t.cx, t.cy);
      c = side_len(t.cx, t.cy, t.ax, t.ay);
      p = a + b + c;
      if (2 * a > p || 2 * b > p || 2 * c > p) begin
         ar = 0;
      end else begin
         prod = 128'(p * (p - 2 * a)) * 128'((p - 2 * b) * (p - 2 * c));
         ar = root128(prod >> (2 * tpac_pkg::FW + 4));
         if (ar > 64'h7F_FFFF_FFFF) ar = 64'h7F_FFFF_FFFF;
      end
      gx = (longint'(t.ax) + longint'(t.bx) + longint'(t.cx)) / 3;
      gy = (longint'(t.ay) + longint'(t.by) + longint'(t.cy)) / 3;
      r.side_ab = a[tpac_pkg::SIDE_W-1:0];
      r.side_bc = b[tpac_pkg::SIDE_W-1:0];
      r.side_ca = c[tpac_pkg::SIDE_W-1:0];
      r.perimeter = p[tpac_pkg::PERIM_W-1:0];
      r.area = ar[tpac_pkg::AREA_W-1:0];
      r.centroid_x = gx[tpac_pkg::CW-1:0];
      r.centroid_y = gy[tpac_pkg::CW-1:0];
      return r;
   endfunction

   task automatic send_triangle(tri_type t);
      req_chan.valid <= 1'b1;
      req_chan.ax <= t.ax; req_chan.ay <= t.ay;
      req_chan.bx <= t.bx; req_chan.by <= t.by;
      req_chan.cx <= t.cx; req_chan.cy <= t.cy;
      do @(posedge clock); while (!req_chan.ready);
      measures_due.push_back(predict_measures(t));
   endtask

   task automatic idle_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   function automatic logic signed [tpac_pkg::CW-1:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return tpac_pkg::CW'($urandom_range(0, 40)) - 16'sd20;
         default: return tpac_pkg::CW'($urandom);
      endcase
   endfunction

   task automatic test_corners();
      tri_type t;
      logic signed [tpac_pkg::CW-1:0] e[4] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1};
      t = '{0, 0, 0, 0, 0, 0};
      send_triangle(t);
      t = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF};
      send_triangle(t);
      t = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
      send_triangle(t);
      t = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sd0};
      send_triangle(t);
      t = '{16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd5, 16'sd9};
      send_triangle(t);
      t = '{16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd4};
      send_triangle(t);
      t = '{-16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd0, -16'sd1};
      send_triangle(t);
      t = '{-16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
      send_triangle(t);
      for (int i = 0; i < 12; i++) begin
         t = '{e[i % 4], e[(i + 1) % 4], e[(i + 2) % 4], e[i / 3], e[(i + 3) % 4],
               e[(i / 2) % 4]};
         send_triangle(t);
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random(int count);
      tri_type t;
      for (int i = 0; i < count; i++) begin
         t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
               rand_coord()};
         if ($urandom_range(0, 5) == 0) begin
            t.cx = t.ax + (t.bx - t.ax) * 2;
            t.cy = t.ay + (t.by - t.ay) * 2;
         end
         send_triangle(t);
         idle_gap();
      end
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_backpressure();
      hold_cycles = 150;
      test_random(120);
      while (measures_due.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         if ($urandom_range(0, 15) == 0) stall_phase <= ~stall_phase;
         rsp_chan.ready <= stall_phase ? ($urandom_range(0, 2) == 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      tpac_pkg::rsp_data_type got;
      tpac_pkg::rsp_data_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.side_ab, rsp_chan.side_bc, rsp_chan.side_ca, rsp_chan.perimeter,
                 rsp_chan.area, rsp_chan.centroid_x, rsp_chan.centroid_y};
         if (measures_due.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("Unexpected result transfer: %p", got);
         end else begin
            want = measures_due.pop_front();
            if (got !== want) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("Mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.ax = '0; req_chan.ay = '0; req_chan.bx = '0;
      req_chan.by = '0; req_chan.cx = '0; req_chan.cy = '0;
      rsp_chan.ready = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_random(300);
      test_backpressure();
      test_random(210);
      while (measures_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (n_mismatch == 0 && measures_due.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
